/* src/double_to_custom_float_round_core_assert.svh */
// Assertion macros used by the checker file.
`ifndef DOUBLE_TO_CUSTOM_FLOAT_ROUND_CORE_ASSERT_SVH
`define DOUBLE_TO_CUSTOM_FLOAT_ROUND_CORE_ASSERT_SVH

// Same-cycle implication.
`define DCFR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define DCFR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* src/dcfr_pkg.sv */
package dcfr_pkg;

   localparam logic CSR_EXP_BITS = 1'b0;
   localparam logic CSR_MAN_BITS = 1'b1;

   localparam logic [3:0] EXP_BITS_RESET = 4'd8;
   localparam logic [5:0] MAN_BITS_RESET = 6'd23;

   localparam logic [10:0] SRC_EXP_ONES = 11'h7FF;

   typedef struct packed {
      logic        sign;
      logic        is_nan;
      logic        is_inf;
      logic        is_zero;
      logic        is_sub;
      logic [10:0] exp;
      logic [51:0] frac;
      logic [5:0]  lzc;
   } dec_type;

   typedef struct packed {
      logic               sign;
      logic               is_nan;
      logic               is_inf;
      logic               is_zero;
      logic [52:0]        q;
      logic               guard;
      logic               sticky;
      logic signed [12:0] uexp;
   } aln_type;

   typedef struct packed {
      logic [63:0] packed_result;
      logic        inexact;
      logic        underflow;
      logic        overflow;
   } res_type;

   function automatic logic [3:0] clamp_exp(input logic [3:0] v);
      if (v < 4'd2) return 4'd2;
      if (v > 4'd11) return 4'd11;
      return v;
   endfunction

   function automatic logic [5:0] clamp_man(input logic [5:0] v);
      if (v < 6'd1) return 6'd1;
      if (v > 6'd52) return 6'd52;
      return v;
   endfunction

   // Leading zeros of a nonzero 52-bit fraction.
   function automatic logic [5:0] lzc52(input logic [51:0] v);
      logic [5:0] n;
      n = 6'd0;
      for (int i = 0; i < 52; i++) begin
         if (v[i]) n = 6'(51 - i);
      end
      return n;
   endfunction

endpackage

/* src/dcfr_decode.sv */
module dcfr_decode
   import dcfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [63:0] in_bits,
   output logic        out_valid,
   output dec_type     out_dec
);

   logic    valid_ff;
   dec_type dec_ff, dec_in;

   always_comb begin
      dec_in.sign    = in_bits[63];
      dec_in.exp     = in_bits[62:52];
      dec_in.frac    = in_bits[51:0];
      dec_in.is_nan  = (in_bits[62:52] == SRC_EXP_ONES) && (in_bits[51:0] != '0);
      dec_in.is_inf  = (in_bits[62:52] == SRC_EXP_ONES) && (in_bits[51:0] == '0);
      dec_in.is_zero = (in_bits[62:52] == '0) && (in_bits[51:0] == '0);
      dec_in.is_sub  = (in_bits[62:52] == '0) && (in_bits[51:0] != '0);
      dec_in.lzc     = lzc52(in_bits[51:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dec_ff <= dec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_dec   = dec_ff;

endmodule

/* src/dcfr_align.sv */
module dcfr_align
   import dcfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic [5:0] man_w,
   input  logic       in_valid,
   input  dec_type    in_dec,
   output logic       out_valid,
   output aln_type    out_aln
);

   logic        valid_ff;
   aln_type     aln_ff, aln_in;
   logic [6:0]  shl;
   logic [52:0] sig;
   logic [5:0]  sh;
   logic [52:0] gtmp;
   logic [52:0] smask;

   always_comb begin
      shl = {1'b0, in_dec.lzc} + 7'd1;
      if (in_dec.is_sub) begin
         sig = {1'b0, in_dec.frac} << shl;
         aln_in.uexp = -13'sd1022 - $signed({6'b0, shl});
      end else begin
         sig = {1'b1, in_dec.frac};
         aln_in.uexp = $signed({2'b0, in_dec.exp}) - 13'sd1023;
      end
      sh    = 6'd52 - man_w;
      gtmp  = (sh == 6'd0) ? 53'd0 : (sig >> (sh - 6'd1));
      smask = (sh == 6'd0) ? 53'd0 : ((53'd1 << (sh - 6'd1)) - 53'd1);
      aln_in.q       = sig >> sh;
      aln_in.guard   = gtmp[0];
      aln_in.sticky  = (sig & smask) != 53'd0;
      aln_in.sign    = in_dec.sign;
      aln_in.is_nan  = in_dec.is_nan;
      aln_in.is_inf  = in_dec.is_inf;
      aln_in.is_zero = in_dec.is_zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         aln_ff <= aln_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_aln   = aln_ff;

endmodule

/* src/dcfr_round.sv */
module dcfr_round
   import dcfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic [3:0] exp_w,
   input  logic [5:0] man_w,
   input  logic       in_valid,
   input  aln_type    in_aln,
   output logic       out_valid,
   output res_type    out_res
);

   logic               valid_ff;
   res_type            res_ff, res_in;
   logic               up;
   logic [53:0]        qr;
   logic [53:0]        qtop;
   logic               carry;
   logic [51:0]        fmask;
   logic [51:0]        frac;
   logic [10:0]        bias;
   logic [11:0]        exp_ones;
   logic signed [13:0] biased;
   logic [63:0]        sign_pos;
   logic [63:0]        ones_pos;
   logic [63:0]        nan_bit;

   always_comb begin
      up       = in_aln.guard && (in_aln.sticky || in_aln.q[0]);
      qr       = {1'b0, in_aln.q} + {53'd0, up};
      qtop     = qr >> ({1'b0, man_w} + 7'd1);
      carry    = qtop != 54'd0;
      fmask    = (52'd1 << man_w) - 52'd1;
      frac     = carry ? 52'd0 : (qr[51:0] & fmask);
      bias     = 11'((12'd1 << (exp_w - 4'd1)) - 12'd1);
      exp_ones = (12'd1 << exp_w) - 12'd1;
      biased   = {in_aln.uexp[12], in_aln.uexp} + $signed({3'b0, bias})
                 + $signed({13'b0, carry});
      sign_pos = {63'd0, in_aln.sign} << ({3'b0, exp_w} + {1'b0, man_w});
      ones_pos = {52'd0, exp_ones} << man_w;
      nan_bit  = 64'd1 << (man_w - 6'd1);

      res_in.overflow  = 1'b0;
      res_in.underflow = 1'b0;
      res_in.inexact   = 1'b0;
      if (in_aln.is_nan) begin
         res_in.packed_result = sign_pos | ones_pos | nan_bit;
      end else if (in_aln.is_inf) begin
         res_in.packed_result = sign_pos | ones_pos;
      end else if (in_aln.is_zero) begin
         res_in.packed_result = sign_pos;
      end else if (biased >= $signed({2'b0, exp_ones})) begin
         res_in.packed_result = sign_pos | ones_pos;
         res_in.overflow      = 1'b1;
         res_in.inexact       = 1'b1;
      end else if (biased < 14'sd1) begin
         res_in.packed_result = sign_pos;
         res_in.underflow     = 1'b1;
         res_in.inexact       = 1'b1;
      end else begin
         res_in.packed_result = sign_pos | ({52'd0, biased[11:0]} << man_w)
                                | {12'd0, frac};
         res_in.inexact       = in_aln.guard || in_aln.sticky;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_res   = res_ff;

endmodule

/* src/double_to_custom_float_round_core.sv */
// Throughput: one transaction per cycle; decode, align and round are each
// one register stage and the whole pipe holds only while the response waits.
// Reset: synchronous, active high; clears the stage valid bits and loads
// exponent_bits = 8 and mantissa_bits = 23.
module double_to_custom_float_round_core
   import dcfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [63:0] source_bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] packed_result
   output logic [2:0]  rsp_tuser,   // [0] overflow, [1] underflow, [2] inexact
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [5:0]  csr_wdata
);

   logic [3:0] exp_bits_ff;
   logic [5:0] man_bits_ff;
   logic       en;
   logic       v1, v2, v3;
   dec_type    dec;
   aln_type    aln;
   res_type    res;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_bits_ff <= EXP_BITS_RESET;
         man_bits_ff <= MAN_BITS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_EXP_BITS: exp_bits_ff <= csr_wdata[3:0];
            CSR_MAN_BITS: man_bits_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance the pipe unless a response is held.
   assign en         = !v3 || rsp_tready;
   assign req_tready = en;

   dcfr_decode u_decode (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_tvalid), .in_bits(req_tdata),
      .out_valid(v1), .out_dec(dec)
   );

   dcfr_align u_align (
      .clock(clock), .reset(reset), .en(en),
      .man_w(clamp_man(man_bits_ff)),
      .in_valid(v1), .in_dec(dec),
      .out_valid(v2), .out_aln(aln)
   );

   dcfr_round u_round (
      .clock(clock), .reset(reset), .en(en),
      .exp_w(clamp_exp(exp_bits_ff)), .man_w(clamp_man(man_bits_ff)),
      .in_valid(v2), .in_aln(aln),
      .out_valid(v3), .out_res(res)
   );

   assign rsp_tvalid = v3;
   assign rsp_tdata  = res.packed_result;
   assign rsp_tuser  = {res.inexact, res.underflow, res.overflow};

endmodule

/* src/dcfr_checker.sv */
`include "double_to_custom_float_round_core_assert.svh"

module dcfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   `DCFR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `DCFR_ASSERT_IMP(a_flags_excl, clock, reset, rsp_tvalid, !(rsp_tuser[0] && rsp_tuser[1]))
   `DCFR_ASSERT_IMP(a_flag_inexact, clock, reset, rsp_tvalid && (rsp_tuser[0] || rsp_tuser[1]), rsp_tuser[2])
   `DCFR_ASSERT_IMP(a_ready_stall, clock, reset, 1'b1, req_tready == (!rsp_tvalid || rsp_tready))

endmodule

bind double_to_custom_float_round_core dcfr_checker u_dcfr_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
);

/* bench/testbench.sv */
module testbench;
   import dcfr_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_we;
   logic        csr_index;
   logic [5:0]  csr_wdata;

   typedef struct {
      logic [63:0] word;
      logic        ovf;
      logic        unf;
      logic        inx;
   } conv_t;

   conv_t       expected_q[$];
   logic [3:0]  exp_width_reg;
   logic [5:0]  man_width_reg;
   int          error_count;
   bit          hold_off;

   double_to_custom_float_round_core u_top (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Compute the rounded minifloat for one binary64 pattern.
   function automatic conv_t convert_double(input logic [63:0] x);
      conv_t       r;
      int          ew;
      int          mw;
      int          sh;
      int          uexp;
      int          biased;
      logic [10:0] sexp;
      logic [63:0] sig;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      logic [63:0] ones;
      logic [63:0] sgn;
      ew = exp_width_reg < 2 ? 2 : (exp_width_reg > 11 ? 11 : exp_width_reg);
      mw = man_width_reg < 1 ? 1 : (man_width_reg > 52 ? 52 : man_width_reg);
      sexp = x[62:52];
      ones = (64'd1 << ew) - 1;
      sgn = 64'(x[63]) << (ew + mw);
      r.ovf = 0;
      r.unf = 0;
      r.inx = 0;
      if (sexp == SRC_EXP_ONES) begin
         r.word = sgn | (ones << mw);
         if (x[51:0] != 0) r.word |= 64'd1 << (mw - 1);
      end else if (sexp == 0 && x[51:0] == 0) begin
         r.word = sgn;
      end else begin
         if (sexp == 0) begin
            sig = {12'd0, x[51:0]};
            uexp = -1022;
            while (sig[52] == 0) begin
               sig = sig << 1;
               uexp--;
            end
         end else begin
            sig = {11'd0, 1'b1, x[51:0]};
            uexp = int'(sexp) - 1023;
         end
         sh = 52 - mw;
         q = sig;
         if (sh > 0) begin
            rem = sig & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            q = sig >> sh;
            if (rem != 0) r.inx = 1;
            if (rem > half || (rem == half && q[0])) q++;
            if ((q >> (mw + 1)) != 0) begin
               q = q >> 1;
               uexp++;
            end
         end
         biased = uexp + (1 << (ew - 1)) - 1;
         if (biased >= int'(ones)) begin
            r.word = sgn | (ones << mw);
            r.ovf = 1;
            r.inx = 1;
         end else if (biased < 1) begin
            r.word = sgn;
            r.unf = 1;
            r.inx = 1;
         end else begin
            r.word = sgn | (64'(biased) << mw) | (q & ((64'd1 << mw) - 1));
         end
      end
      return r;
   endfunction

   // Drop valid only while idling, so back-to-back transactions keep it high.
   task automatic send_double(input logic [63:0] x);
      int idle;
      idle = $urandom_range(0, 9) * ($urandom_range(0, 3) == 0 ? 0 : 1);
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= x;
      do @(posedge clock); while (!req_tready);
      expected_q.push_back(convert_double(x));
      @(negedge clock);
   endtask

   task automatic drain;
      int n;
      n = 0;
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0 && n < 100000) begin
         @(negedge clock);
         n++;
      end
      repeat (6) @(negedge clock);
   endtask

   task automatic write_width(input logic idx, input logic [5:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      if (idx == CSR_EXP_BITS) exp_width_reg = v[3:0];
      else man_width_reg = v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [63:0] random_double;
      logic [63:0] x;
      x = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: x[62:52] = 0;
         1: x[62:52] = SRC_EXP_ONES;
         2: x[62:52] = 11'(1023 + $urandom_range(0, 2100) - 1050);
         3: x[51:0] = x[51:0] & ~((52'd1 << $urandom_range(0, 52)) - 1);
         4: x[62:52] = 11'(1023 + $urandom_range(0, 40) - 20);
         default: ;
      endcase
      return x;
   endfunction

   task automatic test_special_values;
      send_double(64'h0);
      send_double(64'h8000_0000_0000_0000);
      send_double(64'h7FF0_0000_0000_0000);
      send_double(64'hFFF0_0000_0000_0000);
      send_double(64'h7FF8_0000_0000_0000);
      send_double(64'hFFF0_0000_0000_0001);
      send_double(64'h0000_0000_0000_0001);
      send_double(64'h800F_FFFF_FFFF_FFFF);
      send_double(64'h7FEF_FFFF_FFFF_FFFF);
      send_double(64'h3FF0_0000_1000_0000); // tie, even
      send_double(64'h3FF0_0000_3000_0000); // tie, odd
      send_double(64'h3FFF_FFFF_FFFF_FFFF); // carry into exponent
      send_double(64'h3810_0000_0000_0000);
      send_double(64'h380F_FFFF_FFFF_FFFF);
      send_double(64'h47EF_FFFF_F000_0000);
      send_double(64'hFFFF_FFFF_FFFF_FFFF);
      drain();
   endtask

   task automatic test_width_extremes;
      logic [5:0] ew_list[6] = '{6'd2, 6'd11, 6'd0, 6'd15, 6'd5, 6'd8};
      logic [5:0] mw_list[6] = '{6'd1, 6'd52, 6'd0, 6'd63, 6'd10, 6'd23};
      for (int i = 0; i < 6; i++) begin
         write_width(CSR_EXP_BITS, ew_list[i]);
         write_width(CSR_MAN_BITS, mw_list[i]);
         send_double(64'h3FF8_0000_0000_0000);
         send_double(64'h3FFF_FFFF_FFFF_FFFF);
         repeat (40) send_double(random_double());
         drain();
      end
   endtask

   task automatic test_random_stream;
      for (int p = 0; p < 12; p++) begin
         write_width(CSR_EXP_BITS, 6'($urandom_range(0, 15)));
         write_width(CSR_MAN_BITS, 6'($urandom_range(0, 63)));
         repeat (130) send_double(random_double());
         drain();
      end
   endtask

   // Stall the response side for a long stretch so the pipe backs up.
   task automatic test_back_pressure;
      hold_off = 1;
      repeat (40) send_double(random_double());
      drain();
   endtask

   always begin
      int stall;
      int wait_n;
      @(negedge clock);
      if (hold_off) begin
         rsp_tready <= 1'b0;
         for (stall = 0; stall < 200; stall++) @(negedge clock);
         hold_off = 0;
      end
      wait_n = $urandom_range(0, 1) ? 0 : $urandom_range(0, 9);
      if (wait_n == 0) rsp_tready <= 1'b1;
      else begin
         rsp_tready <= 1'b0;
         repeat (wait_n) @(negedge clock);
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      conv_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_tdata);
            error_count++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_tdata !== e.word) begin
               $display("%0t: packed_result expected %h actual %h", $time, e.word, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser !== {e.inx, e.unf, e.ovf}) begin
               $display("%0t: flags expected %b actual %b", $time,
                        {e.inx, e.unf, e.ovf}, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_EXP_BITS;
      csr_wdata = '0;
      error_count = 0;
      hold_off = 0;
      exp_width_reg = EXP_BITS_RESET;
      man_width_reg = MAN_BITS_RESET;
      repeat (5) @(negedge clock);
      reset = 1'b0;
      test_special_values();
      test_width_extremes();
      test_back_pressure();
      test_random_stream();
      if (expected_q.size() == 0 && error_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end
endmodule

/* sim.f */
+incdir+src
src/dcfr_pkg.sv
src/dcfr_decode.sv
src/dcfr_align.sv
src/dcfr_round.sv
src/double_to_custom_float_round_core.sv
src/dcfr_checker.sv
bench/testbench.sv
